// ----- hw/rtl/aes_block_cipher_with_modes_defines.svh -----
// Assertion macros shared by the AES block cipher RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef AES_BLOCK_CIPHER_WITH_MODES_DEFINES_SVH
`define AES_BLOCK_CIPHER_WITH_MODES_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define AES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define AES_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/aes_bcm_pkg.sv -----
// Package for the AES block cipher: payload and control types, codes, tables
// and round functions. Used by the controller, the datapath and the top level.
package aes_bcm_pkg;

	localparam int ROUND_KEY_WORDS = 60;
	localparam int RK_ROWS = ROUND_KEY_WORDS / 4;
	localparam int WORD_W = $clog2(ROUND_KEY_WORDS);
	localparam int ROW_W = $clog2(RK_ROWS);
	localparam int RND_W = 4;
	localparam int REG_IDX_W = 3;
	localparam logic [1:0] MAX_SEL = (ROUND_KEY_WORDS >= 60) ? 2'd2 :
		(ROUND_KEY_WORDS >= 52) ? 2'd1 : 2'd0;

	typedef enum logic [1:0] {
		MODE_ECB = 2'd0,
		MODE_CBC = 2'd1,
		MODE_CFB = 2'd2,
		MODE_OFB = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY0    = 3'd0,
		REG_KEY1    = 3'd1,
		REG_KEY2    = 3'd2,
		REG_KEY3    = 3'd3,
		REG_KEY_LEN = 3'd4,
		REG_MODE    = 3'd5,
		REG_IV_HI   = 3'd6,
		REG_IV_LO   = 3'd7
	} reg_idx_t;

	localparam logic OP_DECRYPT = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic        chain_start;
		logic [63:0] block_hi;
		logic [63:0] block_lo;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} out_item_t;

	typedef struct packed {
		logic              load_in;
		logic              exp_step;
		logic [WORD_W-1:0] exp_idx;
		logic [2:0]        exp_mod;
		logic [ROW_W-1:0]  rk_addr;
		logic              init_st;
		logic              do_round;
		logic              last;
		logic              finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] sel;
		logic       dec;
	} dp_status_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// State byte i (row i % 4, column i / 4) sits at bits 127-8i down.
	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] b;
		for (int i = 0; i < 16; i++) begin
			b = s[127-8*i -: 8];
			o[127-8*i -: 8] = inv ? INV_SBOX[b] : SBOX[b];
		end
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		int src;
		int dst;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					dst = r + 4 * ((c + r) % 4);
					src = r + 4 * c;
				end else begin
					dst = r + 4 * c;
					src = r + 4 * ((c + r) % 4);
				end
				o[127-8*dst -: 8] = s[127-8*src -: 8];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m0 [4];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = s[127-8*(4*c+k) -: 8];
				x2[k] = xtime(a[k]);
				x4[k] = xtime(x2[k]);
				x8[k] = xtime(x4[k]);
				if (inv) begin
					m0[k] = x8[k] ^ x4[k] ^ x2[k];
					m1[k] = x8[k] ^ x2[k] ^ a[k];
					m2[k] = x8[k] ^ x4[k] ^ a[k];
					m3[k] = x8[k] ^ a[k];
				end else begin
					m0[k] = x2[k];
					m1[k] = x2[k] ^ a[k];
					m2[k] = a[k];
					m3[k] = a[k];
				end
			end
			// Coefficient of a[k] in output row r is the one at (k - r) mod 4.
			for (int r = 0; r < 4; r++) begin
				o[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
			end
		end
		return o;
	endfunction

endpackage

// ----- hw/rtl/aes_block_cipher_with_modes.sv -----
// AES-128/192/256 block cipher with ECB, CBC, CFB and OFB chaining.
// A block passes through key fetch, initial key addition and Nr rounds (Nr = 10, 12, 14)
// before out_valid; the first block after a register write first runs key expansion.
// A new block is accepted only once the previous result is registered: the round unit is single and shared.
// Reset (arst_n, asynchronous): registers, chaining value and key-ready flag clear.
module aes_block_cipher_with_modes (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  aes_bcm_pkg::in_item_t             in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output aes_bcm_pkg::out_item_t            out_data,
	input  logic                              cfg_we,
	input  logic [aes_bcm_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                       cfg_wdata
);
	import aes_bcm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	aes_bcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.status    (status),
		.cmd       (cmd)
	);

	aes_bcm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ----- hw/rtl/aes_bcm_ctrl.sv -----
// Controller for the AES block cipher: sequences key expansion, round
// iterations and the output transfer. Depends on aes_bcm_pkg and the defines.
`include "aes_block_cipher_with_modes_defines.svh"

module aes_bcm_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    cfg_we,
	input  aes_bcm_pkg::dp_status_t status,
	output aes_bcm_pkg::dp_cmd_t    cmd
);
	import aes_bcm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXPAND,
		S_FETCH,
		S_LOAD,
		S_ROUND,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              keys_ready_q;
	logic [WORD_W-1:0] widx_q;
	logic [2:0]        wmod_q;
	logic [RND_W-1:0]  rnd_q;
	logic              out_valid_q;

	logic [RND_W-1:0]  nr;
	logic [3:0]        nk;
	logic [WORD_W-1:0] last_word;
	logic              accept;
	logic              finish;

	assign nr        = RND_W'(4'd10 + {1'b0, status.sel, 1'b0});
	assign nk        = 4'd4 + {1'b0, status.sel, 1'b0};
	assign last_word = WORD_W'({nr, 2'b11});
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign finish    = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.exp_step = (state_q == S_EXPAND);
		cmd.exp_idx  = widx_q;
		cmd.exp_mod  = wmod_q;
		cmd.init_st  = (state_q == S_LOAD);
		cmd.do_round = (state_q == S_ROUND);
		cmd.last     = (rnd_q == nr);
		cmd.finish   = finish;
		// The key row is read into a register ahead of its use.
		unique case (state_q)
			S_FETCH: cmd.rk_addr = status.dec ? ROW_W'(nr) : '0;
			S_LOAD:  cmd.rk_addr = status.dec ? ROW_W'(nr - 4'd1) : ROW_W'(1);
			S_ROUND: cmd.rk_addr = status.dec ? ROW_W'(nr - rnd_q - 4'd1) :
				ROW_W'(rnd_q + 4'd1);
			default: cmd.rk_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			keys_ready_q <= 1'b0;
			widx_q       <= '0;
			wmod_q       <= '0;
			rnd_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						widx_q  <= '0;
						wmod_q  <= '0;
						state_q <= keys_ready_q ? S_FETCH : S_EXPAND;
					end
				end
				S_EXPAND: begin
					widx_q <= widx_q + WORD_W'(1);
					wmod_q <= ({1'b0, wmod_q} == nk - 4'd1) ? 3'd0 : wmod_q + 3'd1;
					if (widx_q == last_word) begin
						keys_ready_q <= 1'b1;
						state_q      <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_LOAD;
				S_LOAD: begin
					rnd_q   <= RND_W'(1);
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					if (rnd_q == nr) begin
						state_q <= S_DONE;
					end else begin
						rnd_q <= rnd_q + RND_W'(1);
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// Any register write makes the stored round keys stale.
			if (cfg_we) begin
				keys_ready_q <= 1'b0;
			end
		end
	end

	`AES_ASSERT(a_expand_sets_ready,
		($past(state_q == S_EXPAND) && state_q == S_FETCH) |-> keys_ready_q,
		"expansion finished without marking round keys ready")
	`AES_ASSERT(a_round_bound, (state_q == S_ROUND) |-> (rnd_q <= nr && rnd_q != '0),
		"round counter left the range of the key length")
	`AES_ASSERT(a_finish_after_rounds, (state_q == S_DONE) |-> $past(state_q == S_ROUND ||
		state_q == S_DONE), "result stage entered without running the rounds")
	`AES_ASSERT_NEVER(a_word_bound, (state_q == S_EXPAND) && (widx_q > last_word),
		"key expansion ran past the last round key word")

endmodule

// ----- hw/rtl/aes_bcm_dp.sv -----
// Datapath for the AES block cipher: registers, key expansion, round key
// memory, round unit and chaining. Depends on aes_bcm_pkg.
module aes_bcm_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [aes_bcm_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                          cfg_wdata,
	input  aes_bcm_pkg::in_item_t                in_data,
	output aes_bcm_pkg::out_item_t               out_data,
	input  aes_bcm_pkg::dp_cmd_t                 cmd,
	output aes_bcm_pkg::dp_status_t              status
);
	import aes_bcm_pkg::*;

	logic [63:0]  key_q [4];
	logic [1:0]   klen_q;
	mode_t        mode_q;
	logic [127:0] iv_q;
	logic [127:0] chain_q;

	logic [127:0] blk_q;
	logic [127:0] cv_q;
	logic         op_q;
	logic         start_q;
	logic [127:0] st_q;
	out_item_t    result_q;

	logic [31:0]  win_q [8];
	logic [95:0]  rowbuf_q;
	logic [7:0]   rcon_q;
	logic [127:0] rk_mem [RK_ROWS];
	logic [127:0] rk_q;

	logic [1:0]   sel;
	logic [3:0]   nk;
	logic         dec;
	logic [31:0]  prev_nk;
	logic [31:0]  tw;
	logic [31:0]  key_word;
	logic [31:0]  new_word;
	logic         use_key;
	logic [63:0]  kpair;
	logic [127:0] src;
	logic [127:0] rnd_out;
	logic [127:0] fwd_t;
	logic [127:0] inv_t;
	logic [127:0] res;
	logic [127:0] next_chain;

	always_comb begin
		sel = (klen_q == 2'd3) ? 2'd2 : klen_q;
		if (sel > MAX_SEL) begin
			sel = MAX_SEL;
		end
	end
	assign nk         = 4'd4 + {1'b0, sel, 1'b0};
	assign dec        = (op_q == OP_DECRYPT) && (mode_q == MODE_ECB || mode_q == MODE_CBC);
	assign status.sel = sel;
	assign status.dec = dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			klen_q  <= '0;
			mode_q  <= MODE_ECB;
			iv_q    <= '0;
			chain_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_KEY0:    key_q[0]     <= cfg_wdata;
					REG_KEY1:    key_q[1]     <= cfg_wdata;
					REG_KEY2:    key_q[2]     <= cfg_wdata;
					REG_KEY3:    key_q[3]     <= cfg_wdata;
					REG_KEY_LEN: klen_q       <= cfg_wdata[1:0];
					REG_MODE:    mode_q       <= mode_t'(cfg_wdata[1:0]);
					REG_IV_HI:   iv_q[127:64] <= cfg_wdata;
					REG_IV_LO:   iv_q[63:0]   <= cfg_wdata;
					default:     klen_q       <= klen_q;
				endcase
			end
			if (cmd.finish && (mode_q != MODE_ECB || start_q)) begin
				chain_q <= next_chain;
			end
		end
	end

	// Key expansion, one word per cycle; win_q holds the last eight words.
	assign kpair    = key_q[cmd.exp_idx[2:1]];
	assign key_word = cmd.exp_idx[0] ? kpair[31:0] : kpair[63:32];
	assign use_key  = {{(WORD_W > 4 ? WORD_W-4 : 0){1'b0}}, nk} > cmd.exp_idx;
	assign prev_nk  = win_q[nk[2:0] - 3'd1];

	always_comb begin
		if (cmd.exp_mod == 3'd0) begin
			tw = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && cmd.exp_mod == 3'd4) begin
			tw = sub_word(win_q[0]);
		end else begin
			tw = win_q[0];
		end
		new_word = use_key ? key_word : (prev_nk ^ tw);
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			win_q[0] <= new_word;
			for (int i = 1; i < 8; i++) begin
				win_q[i] <= win_q[i-1];
			end
			rowbuf_q <= {rowbuf_q[63:0], new_word};
			if (cmd.exp_idx == '0) begin
				rcon_q <= 8'h01;
			end else if (!use_key && cmd.exp_mod == 3'd0) begin
				rcon_q <= xtime(rcon_q);
			end
			if (cmd.exp_idx[1:0] == 2'd3) begin
				rk_mem[cmd.exp_idx[WORD_W-1:2]] <= {rowbuf_q, new_word};
			end
		end
		rk_q <= rk_mem[cmd.rk_addr];
	end

	// Round unit and chaining.
	always_comb begin
		unique case (mode_q)
			MODE_ECB: src = blk_q;
			MODE_CBC: src = dec ? blk_q : (blk_q ^ cv_q);
			default:  src = cv_q;
		endcase
		fwd_t = shift_rows(sub_bytes(st_q, 1'b0), 1'b0);
		if (!cmd.last) begin
			fwd_t = mix_columns(fwd_t, 1'b0);
		end
		inv_t = sub_bytes(shift_rows(st_q, 1'b1), 1'b1) ^ rk_q;
		if (!cmd.last) begin
			inv_t = mix_columns(inv_t, 1'b1);
		end
		rnd_out = dec ? inv_t : (fwd_t ^ rk_q);
	end

	always_comb begin
		unique case (mode_q)
			MODE_ECB: begin
				res        = st_q;
				next_chain = cv_q;
			end
			MODE_CBC: begin
				res        = dec ? (st_q ^ cv_q) : st_q;
				next_chain = dec ? blk_q : st_q;
			end
			MODE_CFB: begin
				res        = st_q ^ blk_q;
				next_chain = (op_q == OP_DECRYPT) ? blk_q : (st_q ^ blk_q);
			end
			default: begin
				res        = st_q ^ blk_q;
				next_chain = st_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			blk_q   <= {in_data.block_hi, in_data.block_lo};
			op_q    <= in_data.opcode;
			start_q <= in_data.chain_start;
			cv_q    <= in_data.chain_start ? iv_q : chain_q;
		end
		if (cmd.init_st) begin
			st_q <= src ^ rk_q;
		end else if (cmd.do_round) begin
			st_q <= rnd_out;
		end
		if (cmd.finish) begin
			result_q <= res;
		end
	end

	assign out_data = result_q;

endmodule
